// ===== src/dpop_pkg.sv =====
// ----------------------------------------------------------------------------
// dpop_pkg
// Types and constants shared by the DHCP packet option parser modules.
// ----------------------------------------------------------------------------
package dpop_pkg;

	// byte classes
	localparam logic [3:0] CL_HEADER  = 4'd0;
	localparam logic [3:0] CL_HWADDR  = 4'd1;
	localparam logic [3:0] CL_SNAME   = 4'd2;
	localparam logic [3:0] CL_FILE    = 4'd3;
	localparam logic [3:0] CL_COOKIE  = 4'd4;
	localparam logic [3:0] CL_PAD     = 4'd5;
	localparam logic [3:0] CL_CODE    = 4'd6;
	localparam logic [3:0] CL_LEN     = 4'd7;
	localparam logic [3:0] CL_VALUE   = 4'd8;
	localparam logic [3:0] CL_END     = 4'd9;
	localparam logic [3:0] CL_IGNORED = 4'd10;

	// parse status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD     = 3'd1;
	localparam logic [2:0] ST_NO_END  = 3'd2;
	localparam logic [2:0] ST_LIMIT   = 3'd3;
	localparam logic [2:0] ST_OVERRUN = 3'd4;

	// option codes of interest
	localparam logic [7:0] OPT_PAD      = 8'h00;
	localparam logic [7:0] OPT_END      = 8'hFF;
	localparam logic [7:0] OPT_REQ_ADDR = 8'd50;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;

	// fixed header layout
	localparam logic [7:0] OFF_HWADDR = 8'd28;
	localparam logic [7:0] OFF_SNAME  = 8'd44;
	localparam logic [7:0] OFF_FILE   = 8'd108;
	localparam logic [7:0] OFF_COOKIE = 8'd236;
	localparam logic [7:0] OFF_LAST   = 8'd239;
	localparam logic [7:0] OFF_CIADDR = 8'd12;
	localparam logic [7:0] OFF_CIEND  = 8'd15;

	localparam logic [5:0] SEEN_MAX = 6'd63;

	localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  byte_class;
		logic [5:0]  option_slot;
		logic [7:0]  position;
		logic [7:0]  byte_out;
		logic        packet_done;
		logic [2:0]  parse_status;
		logic [5:0]  option_count;
		logic [7:0]  message_type;
		logic        has_message_type;
		logic [31:0] requested_address;
		logic        has_requested_address;
	} out_item_t;

	// classified byte passed from front to back
	typedef struct packed {
		logic [3:0] byte_class;
		logic [5:0] option_slot;
		logic [7:0] position;
		logic [7:0] data;
		logic       last;
		logic [2:0] status;
		logic [5:0] count;
		logic [7:0] code;
	} mid_item_t;

endpackage

// ===== src/dhcp_packet_option_parser.sv =====
// ----------------------------------------------------------------------------
// dhcp_packet_option_parser
// Byte-wise DHCP packet classifier with option walk and packet summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive request (data_byte, last_byte) with push; a byte
//   is taken at a rising edge with push high and full low. last_byte marks
//   the final byte of a packet and returns the parser to the packet start.
//   Result queue side: while empty is low, result holds the item for the
//   oldest byte; pop high at a rising edge takes it. Exactly one result item
//   comes out per byte, in order.
//   Throughput: one byte per cycle, sustained, as long as results are popped.
//   A result reaches the result ports through the two-entry queue behind
//   the classifier and then the output register.
//   When pop stays low the output register holds its item, the queue fills
//   after two more bytes and full rises; nothing is dropped.
//   Summary fields (status, count, message type, address) are nonzero only
//   on the result of a last byte.
//   Reset (arst_n low) empties queue and output register and starts a new
//   packet at offset zero.
// ----------------------------------------------------------------------------
module dhcp_packet_option_parser
	import dpop_pkg::*;
#(
	parameter int MAX_OPTIONS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  request,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	mid_item_t front_item;
	mid_item_t back_item;
	logic      front_valid;
	logic      fifo_full;
	logic      fifo_valid;
	logic      back_take;

	assign full = fifo_full;

	// classifier front
	dpop_front #(
		.MAX_OPTIONS(MAX_OPTIONS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push),
		.in_item  (request),
		.out_ready(!fifo_full),
		.out_valid(front_valid),
		.out_item (front_item)
	);

	// decoupling queue
	dpop_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid && !fifo_full),
		.wr_item (front_item),
		.full    (fifo_full),
		.rd_en   (back_take),
		.rd_valid(fifo_valid),
		.rd_item (back_item)
	);

	// summary back end
	dpop_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(fifo_valid),
		.in_item (back_item),
		.in_take (back_take),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== src/dpop_front.sv =====
// ----------------------------------------------------------------------------
// dpop_front
// Walks the packet layout byte by byte: fixed header regions, cookie check,
// option code/length/value phases, option limit and end-of-packet status.
// ----------------------------------------------------------------------------
module dpop_front
	import dpop_pkg::*;
#(
	parameter int MAX_OPTIONS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  in_item,
	input  logic      out_ready,
	output logic      out_valid,
	output mid_item_t out_item
);

	localparam logic [7:0] MaxOpt = 8'(MAX_OPTIONS);

	typedef enum logic [2:0] {PH_FIXED, PH_CODE, PH_LEN, PH_VALUE, PH_DONE} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] off_q;
	logic [5:0] seen_q, seen_n;
	logic [7:0] code_q, code_n;
	logic [7:0] left_q, left_n;
	logic [7:0] vidx_q, vidx_n;
	logic       bad_q, bad_n;
	logic       lim_q, lim_n;
	logic       short_pkt;
	logic       accept;
	logic [7:0] b;
	logic [5:0] slot_cur;

	assign accept    = in_valid && out_ready;
	assign out_valid = in_valid;
	assign b         = in_item.data_byte;
	assign slot_cur  = (seen_q == 6'd0) ? 6'd0 : seen_q - 6'd1;

	// classify the byte and work out the next parse state
	always_comb begin
		phase_n   = phase_q;
		seen_n    = seen_q;
		code_n    = code_q;
		left_n    = left_q;
		vidx_n    = vidx_q;
		bad_n     = bad_q;
		lim_n     = lim_q;
		short_pkt = 1'b0;
		out_item  = '0;
		out_item.byte_class = CL_IGNORED;
		out_item.data       = b;
		out_item.last       = in_item.last_byte;
		out_item.code       = code_q;
		case (phase_q)
			PH_FIXED: begin
				if (off_q < OFF_HWADDR) begin
					out_item.byte_class = CL_HEADER;
					out_item.position   = off_q;
				end else if (off_q < OFF_SNAME) begin
					out_item.byte_class = CL_HWADDR;
					out_item.position   = off_q - OFF_HWADDR;
				end else if (off_q < OFF_FILE) begin
					out_item.byte_class = CL_SNAME;
					out_item.position   = off_q - OFF_SNAME;
				end else if (off_q < OFF_COOKIE) begin
					out_item.byte_class = CL_FILE;
					out_item.position   = off_q - OFF_FILE;
				end else begin
					out_item.byte_class = CL_COOKIE;
					out_item.position   = off_q - OFF_COOKIE;
					if (b != COOKIE[off_q[1:0]])
						bad_n = 1'b1;
					if (off_q == OFF_LAST)
						phase_n = bad_n ? PH_DONE : PH_CODE;
				end
				short_pkt = in_item.last_byte && (off_q < OFF_LAST);
			end
			PH_CODE: begin
				if ({2'b00, seen_q} >= MaxOpt) begin
					lim_n   = 1'b1;
					phase_n = PH_DONE;
				end else if (b == OPT_PAD) begin
					out_item.byte_class  = CL_PAD;
					out_item.option_slot = seen_q;
				end else if (b == OPT_END) begin
					out_item.byte_class  = CL_END;
					out_item.option_slot = seen_q;
					phase_n = PH_DONE;
				end else begin
					out_item.byte_class  = CL_CODE;
					out_item.option_slot = seen_q;
					code_n  = b;
					if (seen_q < SEEN_MAX)
						seen_n = seen_q + 6'd1;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				out_item.byte_class  = CL_LEN;
				out_item.option_slot = slot_cur;
				left_n  = b;
				vidx_n  = 8'd0;
				phase_n = (b == 8'd0) ? PH_CODE : PH_VALUE;
			end
			PH_VALUE: begin
				out_item.byte_class  = CL_VALUE;
				out_item.option_slot = slot_cur;
				out_item.position    = vidx_q;
				vidx_n = vidx_q + 8'd1;
				left_n = left_q - 8'd1;
				if (left_n == 8'd0)
					phase_n = PH_CODE;
			end
			default: ;
		endcase

		// packet status on the last byte
		if (in_item.last_byte) begin
			if (short_pkt || bad_n)
				out_item.status = ST_BAD;
			else if (lim_n)
				out_item.status = ST_LIMIT;
			else if (phase_n == PH_DONE)
				out_item.status = ST_OK;
			else if (phase_n == PH_CODE)
				out_item.status = ST_NO_END;
			else
				out_item.status = ST_OVERRUN;
			out_item.count = seen_n;
		end
	end

	// parse state, back to start after each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIXED;
			off_q   <= '0;
			seen_q  <= '0;
			code_q  <= '0;
			left_q  <= '0;
			vidx_q  <= '0;
			bad_q   <= 1'b0;
			lim_q   <= 1'b0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				phase_q <= PH_FIXED;
				off_q   <= '0;
				seen_q  <= '0;
				code_q  <= '0;
				left_q  <= '0;
				vidx_q  <= '0;
				bad_q   <= 1'b0;
				lim_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				if (phase_q == PH_FIXED)
					off_q <= off_q + 8'd1;
				seen_q  <= seen_n;
				code_q  <= code_n;
				left_q  <= left_n;
				vidx_q  <= vidx_n;
				bad_q   <= bad_n;
				lim_q   <= lim_n;
			end
		end
	end

endmodule

// ===== src/dpop_fifo.sv =====
// ----------------------------------------------------------------------------
// dpop_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module dpop_fifo
	import dpop_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  mid_item_t wr_item,
	output logic      full,
	input  logic      rd_en,
	output logic      rd_valid,
	output mid_item_t rd_item
);

	mid_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 2'd1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== src/dpop_back.sv =====
// ----------------------------------------------------------------------------
// dpop_back
// Collects client address, message type and requested address option from
// classified items and drives the registered result item.
// ----------------------------------------------------------------------------
module dpop_back
	import dpop_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  mid_item_t in_item,
	output logic      in_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic [31:0] cli_q, cli_n;
	logic [7:0]  tv_q, tv_n;
	logic        tf_q, tf_n;
	logic [31:0] oa_q, oa_n;
	logic        af_q, af_n;
	logic        cap_q, cap_n;
	logic        out_valid_q;
	out_item_t   result_q;
	out_item_t   res_n;
	logic [7:0]  b;

	assign in_take = in_valid && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign result  = result_q;
	assign b       = in_item.data;

	// summary update for one item
	always_comb begin
		cli_n = cli_q;
		tv_n  = tv_q;
		tf_n  = tf_q;
		oa_n  = oa_q;
		af_n  = af_q;
		cap_n = cap_q;
		if (in_item.byte_class == CL_HEADER && in_item.position >= OFF_CIADDR
				&& in_item.position <= OFF_CIEND)
			cli_n = {cli_q[23:0], b};
		if (in_item.byte_class == CL_LEN)
			cap_n = 1'b0;
		if (in_item.byte_class == CL_VALUE) begin
			if (in_item.code == OPT_MSG_TYPE && in_item.position == 8'd0 && !tf_q) begin
				tv_n = b;
				tf_n = 1'b1;
			end
			if (in_item.code == OPT_REQ_ADDR) begin
				if (in_item.position == 8'd0 && !af_q) begin
					af_n  = 1'b1;
					cap_n = 1'b1;
					oa_n  = {b, 24'd0};
				end else if (cap_q && in_item.position < 8'd4) begin
					case (in_item.position[1:0])
						2'd1:    oa_n = oa_q | {8'd0, b, 16'd0};
						2'd2:    oa_n = oa_q | {16'd0, b, 8'd0};
						2'd3:    oa_n = oa_q | {24'd0, b};
						default: oa_n = oa_q;
					endcase
				end
			end
		end

		// result fields; status on every last byte, the rest of the summary only if it is not bad
		res_n = '0;
		res_n.byte_class  = in_item.byte_class;
		res_n.option_slot = in_item.option_slot;
		res_n.position    = in_item.position;
		res_n.byte_out    = b;
		res_n.packet_done = in_item.last;
		if (in_item.last) begin
			res_n.parse_status = in_item.status;
			if (in_item.status != ST_BAD) begin
				res_n.option_count     = in_item.count;
				res_n.message_type     = tv_n;
				res_n.has_message_type = tf_n;
				if (cli_n != 32'd0) begin
					res_n.requested_address     = cli_n;
					res_n.has_requested_address = 1'b1;
				end else if (af_n) begin
					res_n.requested_address     = oa_n;
					res_n.has_requested_address = 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (in_take)
			result_q <= res_n;
	end

	// summary state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cli_q <= '0;
			tv_q  <= '0;
			tf_q  <= 1'b0;
			oa_q  <= '0;
			af_q  <= 1'b0;
			cap_q <= 1'b0;
		end else begin
			if (in_take)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (in_take) begin
				if (in_item.last) begin
					cli_q <= '0;
					tv_q  <= '0;
					tf_q  <= 1'b0;
					oa_q  <= '0;
					af_q  <= 1'b0;
					cap_q <= 1'b0;
				end else begin
					cli_q <= cli_n;
					tv_q  <= tv_n;
					tf_q  <= tf_n;
					oa_q  <= oa_n;
					af_q  <= af_n;
					cap_q <= cap_n;
				end
			end
		end
	end

endmodule

// ===== src/dpop_checker.sv =====
// ----------------------------------------------------------------------------
// dpop_checker
// Port-level checks of the parser result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dpop_checker
	import dpop_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// summary fields only on the last byte of a packet
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.packet_done) |-> (result.parse_status == ST_OK
		&& result.option_count == 6'd0 && !result.has_message_type
		&& !result.has_requested_address && result.requested_address == 32'd0))
		else $error("summary on a non-final item");

	// bad packet carries no summary
	a_bad_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.packet_done && result.parse_status == ST_BAD) |->
		(result.option_count == 6'd0 && !result.has_message_type
		&& !result.has_requested_address))
		else $error("summary on a bad packet");

	// class and status codes stay in range
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.byte_class <= CL_IGNORED && result.parse_status <= ST_OVERRUN))
		else $error("code out of range");

	// the input side only backs up behind a waiting result
	a_full_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full with no result waiting");

endmodule

bind dhcp_packet_option_parser dpop_checker u_dpop_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks dhcp_packet_option_parser byte by byte against a cycle-free predictor
// of the header walk, cookie check, option walk and packet summary. Directed
// packets cover the short, bad-cookie, bare-header, end-mark, overrun,
// option-limit and address cases; random packets follow, mostly well formed,
// with random gaps on the push side and random stalls on the pop side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dpop_pkg::*;

	localparam int MAX_OPTS = 32;
	localparam int TOTAL_BYTES = 1700;
	// ~1700 bytes, each at worst the longest push gap plus the longest pop stall
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef enum logic [2:0] {PH_HEADER, PH_CODE, PH_LENGTH, PH_VALUE, PH_DONE} walk_phase_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	in_item_t  request = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	dhcp_packet_option_parser #(.MAX_OPTIONS(MAX_OPTS)) dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.request,
		.empty,
		.pop,
		.result
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state, one packet at a time
	walk_phase_t walk_phase;
	logic [15:0] walk_offset;
	logic [5:0]  opts_seen;
	logic [7:0]  cur_code;
	logic [7:0]  val_left;
	logic [7:0]  val_idx;
	logic [31:0] ciaddr;
	logic [31:0] opt_addr;
	logic [7:0]  mtype;
	logic        mtype_found;
	logic        addr_found;
	logic        addr_cap;
	logic [2:0]  walk_err;

	out_item_t   byte_reports[$];
	logic [7:0]  pkt_bytes[$];

	bit idle_on = 1'b0;
	int pop_stall = 0;
	int error_count = 0;
	int results_checked = 0;
	int bytes_sent = 0;
	int useful_bytes = 0;
	int packets_sent = 0;
	int status_hits[8];
	int cycle_count = 0;

	function automatic void clear_walk();
		walk_phase = PH_HEADER;
		walk_offset = '0;
		opts_seen = '0;
		cur_code = '0;
		val_left = '0;
		val_idx = '0;
		ciaddr = '0;
		opt_addr = '0;
		mtype = '0;
		mtype_found = 1'b0;
		addr_found = 1'b0;
		addr_cap = 1'b0;
		walk_err = ST_OK;
	endfunction

	// expected result item for one packet byte; advances the walk
	function automatic out_item_t classify_byte(input logic [7:0] b, input logic lst);
		out_item_t   r;
		logic [15:0] off;
		logic [5:0]  cur_slot;
		logic        short_pkt;
		r = '0;
		r.byte_class = CL_IGNORED;
		r.byte_out = b;
		r.packet_done = lst;
		r.parse_status = ST_OK;
		off = walk_offset;
		cur_slot = (opts_seen == 6'd0) ? 6'd0 : opts_seen - 6'd1;
		short_pkt = 1'b0;
		case (walk_phase)
			PH_HEADER: begin
				if (off < OFF_HWADDR) begin
					r.byte_class = CL_HEADER;
					r.position = 8'(off);
					if (off >= OFF_CIADDR && off <= OFF_CIEND)
						ciaddr = {ciaddr[23:0], b};
				end else if (off < OFF_SNAME) begin
					r.byte_class = CL_HWADDR;
					r.position = 8'(off - OFF_HWADDR);
				end else if (off < OFF_FILE) begin
					r.byte_class = CL_SNAME;
					r.position = 8'(off - OFF_SNAME);
				end else if (off < OFF_COOKIE) begin
					r.byte_class = CL_FILE;
					r.position = 8'(off - OFF_FILE);
				end else begin
					r.byte_class = CL_COOKIE;
					r.position = 8'(off - OFF_COOKIE);
					if (b != COOKIE[off[1:0]])
						walk_err = ST_BAD;
					if (off == OFF_LAST)
						walk_phase = (walk_err == ST_BAD) ? PH_DONE : PH_CODE;
				end
				if (lst && off < OFF_LAST)
					short_pkt = 1'b1;
			end
			PH_CODE: begin
				if (opts_seen >= MAX_OPTS) begin
					walk_err = ST_LIMIT;
					walk_phase = PH_DONE;
				end else if (b == OPT_PAD) begin
					r.byte_class = CL_PAD;
					r.option_slot = opts_seen;
				end else if (b == OPT_END) begin
					r.byte_class = CL_END;
					r.option_slot = opts_seen;
					walk_phase = PH_DONE;
				end else begin
					r.byte_class = CL_CODE;
					r.option_slot = opts_seen;
					cur_code = b;
					if (opts_seen < SEEN_MAX)
						opts_seen = opts_seen + 6'd1;
					walk_phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				r.byte_class = CL_LEN;
				r.option_slot = cur_slot;
				val_left = b;
				val_idx = '0;
				addr_cap = 1'b0;
				walk_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
			end
			PH_VALUE: begin
				r.byte_class = CL_VALUE;
				r.option_slot = cur_slot;
				r.position = val_idx;
				if (cur_code == OPT_MSG_TYPE && val_idx == 8'd0 && !mtype_found) begin
					mtype = b;
					mtype_found = 1'b1;
				end
				// first address option only, big-endian, first four bytes
				if (cur_code == OPT_REQ_ADDR) begin
					if (val_idx == 8'd0 && !addr_found) begin
						addr_found = 1'b1;
						addr_cap = 1'b1;
						opt_addr = {b, 24'h0};
					end else if (addr_cap && val_idx < 8'd4) begin
						opt_addr = opt_addr | (32'(b) << (8 * (3 - val_idx)));
					end
				end
				val_idx = val_idx + 8'd1;
				val_left = val_left - 8'd1;
				if (val_left == 8'd0) begin
					addr_cap = 1'b0;
					walk_phase = PH_CODE;
				end
			end
			default: ;
		endcase

		if (walk_offset != 16'hFFFF)
			walk_offset = walk_offset + 16'd1;

		// summary on the last byte, then back to the packet start
		if (lst) begin
			if (short_pkt || walk_err == ST_BAD) begin
				r.parse_status = ST_BAD;
			end else begin
				if (walk_err == ST_LIMIT)
					r.parse_status = ST_LIMIT;
				else if (walk_phase == PH_DONE)
					r.parse_status = ST_OK;
				else if (walk_phase == PH_CODE)
					r.parse_status = ST_NO_END;
				else
					r.parse_status = ST_OVERRUN;
				r.option_count = opts_seen;
				r.message_type = mtype;
				r.has_message_type = mtype_found;
				if (ciaddr != 32'd0) begin
					r.requested_address = ciaddr;
					r.has_requested_address = 1'b1;
				end else if (addr_found) begin
					r.requested_address = opt_addr;
					r.has_requested_address = 1'b1;
				end
			end
			clear_walk();
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones, none while idling is off
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic string field_diffs(input out_item_t e, input out_item_t g);
		string s;
		s = "";
		if (g.byte_class !== e.byte_class)
			s = {s, $sformatf(" class %0d/%0d", e.byte_class, g.byte_class)};
		if (g.option_slot !== e.option_slot)
			s = {s, $sformatf(" slot %0d/%0d", e.option_slot, g.option_slot)};
		if (g.position !== e.position)
			s = {s, $sformatf(" pos %0d/%0d", e.position, g.position)};
		if (g.byte_out !== e.byte_out)
			s = {s, $sformatf(" byte %h/%h", e.byte_out, g.byte_out)};
		if (g.packet_done !== e.packet_done)
			s = {s, $sformatf(" done %b/%b", e.packet_done, g.packet_done)};
		if (g.parse_status !== e.parse_status)
			s = {s, $sformatf(" status %0d/%0d", e.parse_status, g.parse_status)};
		if (g.option_count !== e.option_count)
			s = {s, $sformatf(" count %0d/%0d", e.option_count, g.option_count)};
		if (g.message_type !== e.message_type)
			s = {s, $sformatf(" mtype %h/%h", e.message_type, g.message_type)};
		if (g.has_message_type !== e.has_message_type)
			s = {s, $sformatf(" has_mtype %b/%b", e.has_message_type, g.has_message_type)};
		if (g.requested_address !== e.requested_address)
			s = {s, $sformatf(" addr %h/%h", e.requested_address, g.requested_address)};
		if (g.has_requested_address !== e.has_requested_address)
			s = {s, $sformatf(" has_addr %b/%b", e.has_requested_address,
				g.has_requested_address)};
		return s;
	endfunction

	// result side: check each popped item, then pick the next pop level
	always @(posedge clk) begin : take_results
		out_item_t want;
		string     diffs;
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (byte_reports.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("result %0d arrived with no item pending: byte %h class %0d",
						results_checked, result.byte_out, result.byte_class);
			end else begin
				want = byte_reports.pop_front();
				diffs = field_diffs(want, result);
				if (diffs != "") begin
					error_count++;
					if (error_count <= 10)
						$display("result %0d mismatch (expected/actual):%s",
							results_checked, diffs);
				end
			end
		end
		if (pop_stall > 0) begin
			pop_stall--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			pop_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items pending", cycle_count,
				byte_reports.size());
			$display("dhcp_packet_option_parser verification failed");
			$finish;
		end
	end

	// push one byte; push is left high so the next item can follow directly
	task automatic send_byte(input logic [7:0] b, input logic lst);
		out_item_t next_report;
		int        gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		request <= '{data_byte: b, last_byte: lst};
		@(posedge clk);
		while (full)
			@(posedge clk);
		next_report = classify_byte(b, lst);
		byte_reports.push_back(next_report);
		bytes_sent++;
		if (next_report.byte_class != CL_IGNORED)
			useful_bytes++;
		if (lst)
			status_hits[next_report.parse_status]++;
	endtask

	// drop push and hold off until every pending item has come back
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (byte_reports.size() != 0);
	endtask

	// fixed header with random fill, a given client address and cookie fault
	function automatic void start_packet(input logic [31:0] ci, input int bad_at);
		pkt_bytes.delete();
		for (int i = 0; i < OFF_COOKIE; i++) begin
			if (i >= OFF_CIADDR && i <= OFF_CIEND)
				pkt_bytes.push_back(ci[8 * (OFF_CIEND - i) +: 8]);
			else
				pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < 4; i++) begin
			if (i == bad_at)
				pkt_bytes.push_back(COOKIE[i] ^ 8'($urandom_range(1, 255)));
			else
				pkt_bytes.push_back(COOKIE[i]);
		end
	endfunction

	function automatic void add_option(input logic [7:0] code, input int len);
		pkt_bytes.push_back(code);
		pkt_bytes.push_back(8'(len));
		repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// send the first n bytes of the built packet, the n-th marked last
	task automatic send_packet(input int n);
		if (n > pkt_bytes.size())
			n = pkt_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(pkt_bytes[i], i == n - 1);
		packets_sent++;
	endtask

	task automatic test_short_packets();
		idle_on = 1'b0;
		start_packet(32'h0, -1);
		pkt_bytes[0] = 8'hFF;
		send_packet(1);
		// ends one byte before the last cookie byte
		send_packet(239);
	endtask

	task automatic test_bad_cookie();
		idle_on = 1'b0;
		// nonzero client address must not leak into the summary
		start_packet(32'($urandom_range(1, 65535)), $urandom_range(0, 3));
		send_packet(240);
	endtask

	task automatic test_bare_header();
		idle_on = 1'b1;
		start_packet(32'hFFFF_FFFF, -1);
		send_packet(240);
	endtask

	task automatic test_end_mark();
		idle_on = 1'b1;
		// empty options are skipped, short address zero-filled, later ones ignored
		start_packet(32'h0, -1);
		pkt_bytes.push_back(OPT_PAD);
		add_option(OPT_MSG_TYPE, 0);
		add_option(OPT_REQ_ADDR, 0);
		add_option(OPT_REQ_ADDR, 2);
		pkt_bytes.push_back(OPT_PAD);
		add_option(OPT_REQ_ADDR, 4);
		add_option(OPT_MSG_TYPE, 1);
		add_option(OPT_MSG_TYPE, 3);
		pkt_bytes.push_back(OPT_END);
		// trailing bytes after the end mark are ignored
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'hFF);
		pkt_bytes.push_back(OPT_MSG_TYPE);
		send_packet(pkt_bytes.size());
	endtask

	task automatic test_overrun();
		idle_on = 1'b1;
		// ends inside a long address option, only the first four bytes count
		start_packet(32'h0, -1);
		add_option(OPT_MSG_TYPE, 1);
		add_option(OPT_REQ_ADDR, 7);
		send_packet(pkt_bytes.size() - 2);
	endtask

	task automatic test_option_limit();
		idle_on = 1'b1;
		start_packet(32'h0, -1);
		for (int k = 0; k < MAX_OPTS; k++)
			add_option(8'($urandom_range(1, 254)), 0);
		// code byte past the limit
		pkt_bytes.push_back(OPT_MSG_TYPE);
		send_packet(pkt_bytes.size());
	endtask

	// builds a random packet and returns how many of its bytes to send
	function automatic int build_random_packet();
		int n;
		int bad;
		int nopt;
		int pick;
		int lr;
		int len;
		if ($urandom_range(0, 99) < 15) begin
			pkt_bytes.delete();
			n = $urandom_range(1, 300);
			repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
			return n;
		end
		bad = -1;
		if ($urandom_range(0, 99) < 8)
			bad = $urandom_range(0, 3);
		start_packet(($urandom_range(0, 1) != 0) ? 32'h0 : 32'($urandom), bad);
		nopt = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 10);
		for (int k = 0; k < nopt; k++) begin
			pick = $urandom_range(0, 99);
			lr = $urandom_range(0, 99);
			if (lr < 85)
				len = $urandom_range(0, 6);
			else if (lr < 97)
				len = $urandom_range(7, 40);
			else
				len = $urandom_range(41, 255);
			if (pick < 15)
				pkt_bytes.push_back(OPT_PAD);
			else if (pick < 35)
				add_option(OPT_MSG_TYPE, len);
			else if (pick < 55)
				add_option(OPT_REQ_ADDR, len);
			else
				add_option(8'($urandom_range(1, 254)), len);
		end
		if ($urandom_range(0, 99) < 80) begin
			pkt_bytes.push_back(OPT_END);
			repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end
		n = pkt_bytes.size();
		// truncate some packets somewhere in the option area
		if ($urandom_range(0, 99) < 20)
			n = $urandom_range(240, n);
		return n;
	endfunction

	task automatic test_random_packets();
		int n;
		while (bytes_sent < TOTAL_BYTES) begin
			idle_on = ($urandom_range(0, 3) != 0);
			n = build_random_packet();
			// keep the run within its byte budget
			if (n > TOTAL_BYTES - bytes_sent)
				n = TOTAL_BYTES - bytes_sent;
			send_packet(n);
			// sender holds until all results are back
			wait_drained();
		end
	endtask

	initial begin
		clear_walk();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_packets();
		test_bad_cookie();
		test_bare_header();
		test_end_mark();
		test_overrun();
		test_option_limit();
		test_random_packets();
		wait_drained();
		repeat (10) @(posedge clk);
		$display("covered %0d packets, %0d bytes (%0d classified), %0d results checked",
			packets_sent, bytes_sent, useful_bytes, results_checked);
		$display("packet outcomes: ok %0d, short/bad cookie %0d, no end %0d,",
			status_hits[ST_OK], status_hits[ST_BAD], status_hits[ST_NO_END]);
		$display("  limit %0d, overrun %0d",
			status_hits[ST_LIMIT], status_hits[ST_OVERRUN]);
		if (error_count == 0)
			$display("dhcp_packet_option_parser verification clean");
		else
			$display("dhcp_packet_option_parser verification failed");
		$finish;
	end

endmodule
